/* hw/rtl/usdbv_pkg.sv */
// Package for the unique stack with delete by value.
// Holds the sizes, operation codes and status codes; depends on nothing.
package usdbv_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 10;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [2:0] t_status;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_FULL     = 3'd1;
    localparam t_status ST_EMPTY    = 3'd2;
    localparam t_status ST_NOTFOUND = 3'd3;
    localparam t_status ST_DUP      = 3'd4;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

endpackage

/* hw/rtl/unique_stack_delete_by_value.sv */
// Top level of the unique stack with delete by value.
// Depends on usdbv_pkg for sizes and codes.
//
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with o_valid high, and the receiver
// cannot stall it. The block works on one request at a time with a single
// equality comparator and a single register-file read port: a search walks
// from the top entry down, one entry per cycle, and a removal then moves the
// entries above the hole down, one per cycle. busy stays high from acceptance
// until the result is shown.
module unique_stack_delete_by_value
    import usdbv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  logic [9:0]            i_value,
    output logic                  o_valid,
    output logic [2:0]            o_status,
    output logic [4:0]            o_count,
    output logic [9:0]            o_top_value,
    output logic [3:0]            o_removed_position
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_RESULT
    } t_state;

    t_state                r_state;
    logic                  r_op;
    logic [VALUE_BITS-1:0] r_value;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_pos;
    t_status               r_status;
    logic                  r_valid;
    t_status               r_o_status;
    logic [CNT_W-1:0]      r_o_count;
    logic [VALUE_BITS-1:0] r_o_top;
    logic [IDX_W-1:0]      r_o_pos;

    logic [VALUE_BITS-1:0] r_mem [DEPTH];

    logic [IDX_W-1:0]      rd_addr;
    logic [VALUE_BITS-1:0] rd_data;
    logic                  hit;
    logic [CNT_W-1:0]      idx_next;
    logic [IDX_W-1:0]      top_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [VALUE_BITS-1:0] wr_data;

    assign idx_next = {1'b0, r_idx} + CNT_W'(1);
    assign top_addr = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        case (r_state)
            S_SHIFT:  rd_addr = idx_next[IDX_W-1:0];
            S_RESULT: rd_addr = top_addr;
            default:  rd_addr = r_idx;
        endcase
    end

    assign rd_data = r_mem[rd_addr];
    assign hit     = (rd_data == r_value);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = rd_data;
        if (r_state == S_IDLE && start && i_operation == OP_PUSH
                && r_count == CNT_W'(0)) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = i_value[VALUE_BITS-1:0];
        end else if (r_state == S_SEARCH && !hit && r_idx == '0
                && r_op == OP_PUSH) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IDX_W-1:0];
            wr_data = r_value;
        end else if (r_state == S_SHIFT && idx_next < r_count) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
            wr_data = rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_operation;
                        r_value  <= i_value[VALUE_BITS-1:0];
                        r_status <= ST_OK;
                        r_pos    <= '0;
                        r_idx    <= top_addr;
                        if (i_operation == OP_PUSH) begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_RESULT;
                            end else if (r_count == CNT_W'(0)) begin
                                r_count <= CNT_W'(1);
                                r_state <= S_RESULT;
                            end else begin
                                r_state <= S_SEARCH;
                            end
                        end else begin
                            if (r_count == CNT_W'(0)) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_RESULT;
                            end else begin
                                r_state <= S_SEARCH;
                            end
                        end
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        if (r_op == OP_PUSH) begin
                            r_status <= ST_DUP;
                            r_state  <= S_RESULT;
                        end else begin
                            r_pos   <= r_idx;
                            r_state <= S_SHIFT;
                        end
                    end else if (r_idx == '0) begin
                        if (r_op == OP_PUSH) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_status <= ST_NOTFOUND;
                        end
                        r_state <= S_RESULT;
                    end else begin
                        r_idx <= r_idx - IDX_W'(1);
                    end
                end
                S_SHIFT: begin
                    if (idx_next < r_count) begin
                        r_idx <= idx_next[IDX_W-1:0];
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    r_valid    <= 1'b1;
                    r_o_status <= r_status;
                    r_o_count  <= r_count;
                    r_o_top    <= (r_count == CNT_W'(0)) ? '0 : rd_data;
                    r_o_pos    <= r_pos;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy               = (r_state != S_IDLE);
    assign o_valid            = r_valid;
    assign o_status           = r_o_status;
    assign o_count            = r_o_count;
    assign o_top_value        = r_o_top;
    assign o_removed_position = r_o_pos;

endmodule
